>>> design/e2r_pkg.sv
// Shared constants and types for the Euler-angle to rotation-matrix pipeline.
package e2r_pkg;

  localparam int ZW           = 34;
  localparam int XW           = 34;
  localparam int TW           = 22;
  localparam int PW           = 2 * TW;
  localparam int SW           = 64;
  localparam int CORDIC_STEPS = 16;
  localparam int Z_FRAC       = 29;
  localparam int TRIG_FRAC    = 20;
  localparam int TRIG_SHIFT   = 30 - TRIG_FRAC;

  localparam logic signed [ZW-1:0] PI_Z       = 34'sd1686629713;
  localparam logic signed [ZW-1:0] HALF_PI_Z  = 34'sd843314857;
  localparam logic signed [XW-1:0] CORDIC_K   = 34'sd652032874;
  localparam logic signed [XW-1:0] TRIG_ROUND = 34'sd512;

  typedef logic signed [ZW-1:0] zval_t;
  typedef logic signed [XW-1:0] xval_t;
  typedef logic signed [TW-1:0] trig_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  localparam zval_t ATAN_TAB [CORDIC_STEPS] = '{
    34'sd421657428, 34'sd248918915, 34'sd131521918, 34'sd66762579,
    34'sd33510843,  34'sd16771758,  34'sd8387925,   34'sd4194219,
    34'sd2097141,   34'sd1048575,   34'sd524288,    34'sd262144,
    34'sd131072,    34'sd65536,     34'sd32768,     34'sd16384
  };

endpackage

>>> design/e2r_sincos.sv
// Pipelined CORDIC sine/cosine unit, one stage per iteration.
module e2r_sincos import e2r_pkg::*; #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output trig_t                         cos_val,
  output trig_t                         sin_val
);

  localparam int ZSHIFT = Z_FRAC - (ANGLE_WIDTH - 3);

  zval_t xs [CORDIC_STEPS+1];
  zval_t ys [CORDIC_STEPS+1];
  zval_t zs [CORDIC_STEPS+1];
  logic  neg [CORDIC_STEPS+1];

  zval_t z_in;
  zval_t z_fold;
  logic  neg_in;

  always_comb begin
    z_in   = ZW'(angle) <<< ZSHIFT;
    z_fold = z_in;
    neg_in = 1'b0;
    if (z_in > HALF_PI_Z) begin
      z_fold = z_in - PI_Z;
      neg_in = 1'b1;
    end else if (z_in < -HALF_PI_Z) begin
      z_fold = z_in + PI_Z;
      neg_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]  <= CORDIC_K;
      ys[0]  <= '0;
      zs[0]  <= z_fold;
      neg[0] <= neg_in;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_TAB[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_TAB[i];
        end
        neg[i+1] <= neg[i];
      end
    end
  end

  xval_t xr;
  xval_t yr;

  always_comb begin
    xr = (xs[CORDIC_STEPS] + TRIG_ROUND) >>> TRIG_SHIFT;
    yr = (ys[CORDIC_STEPS] + TRIG_ROUND) >>> TRIG_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= neg[CORDIC_STEPS] ? -TW'(xr) : TW'(xr);
      sin_val <= neg[CORDIC_STEPS] ? -TW'(yr) : TW'(yr);
    end
  end

endmodule

>>> design/euler_to_rotation_matrix.sv
// Throughput: one transaction per cycle unless the output stalls; each CORDIC
// iteration is its own stage.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset: synchronous, active high; clears the valid bits only.
module euler_to_rotation_matrix import e2r_pkg::*; #(
  parameter int ANGLE_WIDTH = 16,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ANGLE_WIDTH-1:0] roll_angle,
  input  logic signed [ANGLE_WIDTH-1:0] pitch_angle,
  input  logic signed [ANGLE_WIDTH-1:0] yaw_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COEF_WIDTH-1:0]  r00,
  output logic signed [COEF_WIDTH-1:0]  r01,
  output logic signed [COEF_WIDTH-1:0]  r02,
  output logic signed [COEF_WIDTH-1:0]  r10,
  output logic signed [COEF_WIDTH-1:0]  r11,
  output logic signed [COEF_WIDTH-1:0]  r12,
  output logic signed [COEF_WIDTH-1:0]  r20,
  output logic signed [COEF_WIDTH-1:0]  r21,
  output logic signed [COEF_WIDTH-1:0]  r22
);

  localparam int DEPTH = CORDIC_STEPS + 5;
  localparam int RSH   = 3 * TRIG_FRAC - (COEF_WIDTH - 2);
  localparam sum_t LIM  = sum_t'(1) <<< (COEF_WIDTH - 2);
  localparam sum_t RHALF = sum_t'(1) <<< (RSH - 1);

  logic en;
  logic vld [DEPTH];

  assign en        = !vld[DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < DEPTH; k++) vld[k] <= vld[k-1];
    end
  end

  trig_t cb, sb, ca, sa, ch, sh;

  e2r_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
    .clk(clk), .en(en), .angle(roll_angle), .cos_val(cb), .sin_val(sb));
  e2r_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
    .clk(clk), .en(en), .angle(pitch_angle), .cos_val(ca), .sin_val(sa));
  e2r_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
    .clk(clk), .en(en), .angle(yaw_angle), .cos_val(ch), .sin_val(sh));

  // pair products
  prod_t p_chca, p_shsb, p_chsa, p_shcb, p_cacb, p_casb, p_shca, p_shsa, p_chsb, p_chcb;
  trig_t d_sa, d_sb, d_cb;

  always_ff @(posedge clk) begin
    if (en) begin
      p_chca <= ch * ca;
      p_shsb <= sh * sb;
      p_chsa <= ch * sa;
      p_shcb <= sh * cb;
      p_cacb <= ca * cb;
      p_casb <= ca * sb;
      p_shca <= sh * ca;
      p_shsa <= sh * sa;
      p_chsb <= ch * sb;
      p_chcb <= ch * cb;
      d_sa   <= sa;
      d_sb   <= sb;
      d_cb   <= cb;
    end
  end

  // Q.60 entry sums
  sum_t t [9];

  always_ff @(posedge clk) begin
    if (en) begin
      t[0] <= SW'(p_chca) <<< TRIG_FRAC;
      t[1] <= (SW'(p_shsb) <<< TRIG_FRAC) - SW'(p_chsa) * SW'(d_cb);
      t[2] <= SW'(p_chsa) * SW'(d_sb) + (SW'(p_shcb) <<< TRIG_FRAC);
      t[3] <= SW'(d_sa) <<< (2 * TRIG_FRAC);
      t[4] <= SW'(p_cacb) <<< TRIG_FRAC;
      t[5] <= -(SW'(p_casb) <<< TRIG_FRAC);
      t[6] <= -(SW'(p_shca) <<< TRIG_FRAC);
      t[7] <= SW'(p_shsa) * SW'(d_cb) + (SW'(p_chsb) <<< TRIG_FRAC);
      t[8] <= (SW'(p_chcb) <<< TRIG_FRAC) - SW'(p_shsa) * SW'(d_sb);
    end
  end

  sum_t rnd [9];
  logic signed [COEF_WIDTH-1:0] coef [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rnd[k] = (t[k] + RHALF) >>> RSH;
      if (rnd[k] > LIM) rnd[k] = LIM;
      if (rnd[k] < -LIM) rnd[k] = -LIM;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) coef[k] <= COEF_WIDTH'(rnd[k]);
    end
  end

  assign r00 = coef[0];
  assign r01 = coef[1];
  assign r02 = coef[2];
  assign r10 = coef[3];
  assign r11 = coef[4];
  assign r12 = coef[5];
  assign r20 = coef[6];
  assign r21 = coef[7];
  assign r22 = coef[8];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(r00) && $stable(r22))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pipeline stalled with empty output");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

endmodule

>>> tb/euler_to_rotation_matrix_tb.sv
// Testbench for euler_to_rotation_matrix: predicts the rotation matrix per transaction and checks it.
module euler_to_rotation_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW = 16;
  localparam int CW = 16;
  localparam int LATENCY = 21;
  localparam longint PI_Q29 = 64'sd1686629713;
  localparam longint HALF_PI_Q29 = 64'sd843314857;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint ANGLE_MAX = 25736;

  typedef struct {
    logic signed [CW-1:0] m [9];
  } matrix_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [AW-1:0] roll_angle = '0;
  logic signed [AW-1:0] pitch_angle = '0;
  logic signed [AW-1:0] yaw_angle = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [CW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  matrix_t pending_matrices [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  bit failed = 0;

  longint arctan_q29 [16] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144,
    131072, 65536, 32768, 16384
  };

  euler_to_rotation_matrix dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic sin_cos(input logic signed [AW-1:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) <<< (29 - (AW - 3));
    flip = 0;
    x = GAIN_Q30;
    y = 0;
    if (z > HALF_PI_Q29) begin
      z -= PI_Q29;
      flip = 1;
    end else if (z < -HALF_PI_Q29) begin
      z += PI_Q29;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q29[i];
      end else begin
        x += dx; y -= dy; z += arctan_q29[i];
      end
    end
    x = (x + 512) >>> 10;
    y = (y + 512) >>> 10;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic signed [CW-1:0] round_coef(input longint v);
    longint r, lim;
    lim = longint'(1) <<< (CW - 2);
    r = (v + (longint'(1) <<< (60 - (CW - 2) - 1))) >>> (60 - (CW - 2));
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[CW-1:0];
  endfunction

  task automatic predict_matrix(input logic signed [AW-1:0] rl, pt, yw, output matrix_t mx);
    longint cb, sb, ca, sa, ch, sh, up;
    up = longint'(1) <<< 20;
    sin_cos(rl, cb, sb);
    sin_cos(pt, ca, sa);
    sin_cos(yw, ch, sh);
    mx.m[0] = round_coef(ch * ca * up);
    mx.m[1] = round_coef(sh * sb * up - ch * sa * cb);
    mx.m[2] = round_coef(ch * sa * sb + sh * cb * up);
    mx.m[3] = round_coef(sa * up * up);
    mx.m[4] = round_coef(ca * cb * up);
    mx.m[5] = round_coef(-(ca * sb) * up);
    mx.m[6] = round_coef(-(sh * ca) * up);
    mx.m[7] = round_coef(sh * sa * cb + ch * sb * up);
    mx.m[8] = round_coef(ch * cb * up - sh * sa * sb);
  endtask

  task automatic send_angles(input logic signed [AW-1:0] rl, pt, yw);
    matrix_t mx;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    predict_matrix(rl, pt, yw, mx);
    in_valid <= 1;
    roll_angle <= rl;
    pitch_angle <= pt;
    yaw_angle <= yw;
    do @(posedge clk); while (!in_ready);
    pending_matrices.push_back(mx);
  endtask

  function automatic logic signed [AW-1:0] rand_angle();
    case ($urandom_range(4))
      0: return AW'(ANGLE_MAX);
      1: return AW'(-ANGLE_MAX);
      default: return AW'($urandom_range(2 * ANGLE_MAX) - ANGLE_MAX);
    endcase
  endfunction

  // Result checker.
  always @(posedge clk) begin
    logic signed [CW-1:0] got [9];
    matrix_t exp_mx;
    string names [9];
    names = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};
    if (!rst && out_valid && out_ready) begin
      got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
      if (pending_matrices.size() == 0) begin
        $error("result with no transaction pending");
        failed = 1;
      end else begin
        exp_mx = pending_matrices.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== exp_mx.m[i]) begin
            $error("%s expected %0d got %0d", names[i], exp_mx.m[i], got[i]);
            failed = 1;
          end
      end
    end
  end

  // Receiver stalls and long hold-off.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic drain();
    in_valid <= 0;
    while (pending_matrices.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic signed [AW-1:0] corners [8];
    corners = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
                16'sd12869, -16'sd12869, 16'sd6434};
    for (int i = 0; i < 8; i++) send_angles(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
    send_angles(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_angles(16'sh8000, 16'sh7fff, 16'sh8000);
    send_angles(16'shffff, 16'sh5555, 16'shaaaa);
    send_angles(16'sh5555, 16'shaaaa, 16'sh0001);
    send_angles(16'sd25735, 16'sd12867, -16'sd25735);
    send_angles(-16'sd6434, 16'sd0, 16'sd12868);
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0)
        send_angles(AW'($urandom), AW'($urandom), AW'($urandom));
      else
        send_angles(rand_angle(), rand_angle(), rand_angle());
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 200;
    for (int i = 0; i < 40; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
    drain();
    send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(150, 0, 0);
    test_random(130, 54, 0);
    test_random(130, 0, 54);
    test_random(130, 11, 11);
    test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    repeat (LATENCY + 5) @(posedge clk);
    if (!failed && pending_matrices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
